FILE: hw/rtl/lcvs_pkg.sv
// Types and constants shared by the victim select block.
package lcvs_pkg;

   typedef enum logic [1:0] {
      CMD_INVALIDATE = 2'd0,
      CMD_FILL       = 2'd1,
      CMD_VICTIM     = 2'd2
   } cmd_type;

   typedef struct packed {
      logic [1:0] command;
      logic [5:0] set_index;
      logic [2:0] way_index;
   } req_type;

   typedef struct packed {
      logic [2:0] victim_way;
      logic       victim_was_free;
   } rsp_type;

   typedef struct packed {
      logic write;
      logic has_rsp;
   } upd_ctl_type;

   localparam logic [3:0] LFSR_SEED      = 4'h1;
   localparam logic [3:0] LFSR_HIGH_MASK = 4'hE;

endpackage

FILE: hw/rtl/lcvs_row_update.sv
// Next-state and victim choice for one cache set row.
module lcvs_row_update #(
   parameter int WAYS = 8
) (
   input  lcvs_pkg::req_type     item,
   input  logic                  set_ok,
   input  logic [WAYS-1:0]       row_valid,
   input  logic [3:0]            row_lfsr,
   output logic [WAYS-1:0]       new_valid,
   output logic [3:0]            new_lfsr,
   output lcvs_pkg::rsp_type     rsp,
   output lcvs_pkg::upd_ctl_type ctl
);
   import lcvs_pkg::*;

   logic [2:0]      mod_tab [16];
   logic [3:0]      lfsr_step;
   logic [WAYS-1:0] way_bit;
   logic            way_ok;
   logic            any_free;
   logic [2:0]      first_free;

   for (genvar g = 0; g < 16; g++) begin : g_mod
      assign mod_tab[g] = 3'(g % WAYS);
   end

   assign lfsr_step = ((row_lfsr << 1) & LFSR_HIGH_MASK) | {3'b000, row_lfsr[3] ^ row_lfsr[2]};
   assign way_ok    = (32'(item.way_index) < WAYS);
   assign way_bit   = {{(WAYS-1){1'b0}}, 1'b1} << item.way_index;

   always_comb begin
      any_free   = 1'b0;
      first_free = 3'd0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (!row_valid[w]) begin
            any_free   = 1'b1;
            first_free = 3'(w);
         end
      end
   end

   always_comb begin
      new_valid       = row_valid;
      new_lfsr        = row_lfsr;
      rsp.victim_way  = first_free;
      rsp.victim_was_free = 1'b1;
      ctl.write       = 1'b0;
      ctl.has_rsp     = 1'b0;
      unique case (cmd_type'(item.command))
         CMD_INVALIDATE: begin
            new_valid = row_valid & ~way_bit;
            ctl.write = set_ok && way_ok;
         end
         CMD_FILL: begin
            new_valid = row_valid | way_bit;
            ctl.write = set_ok && way_ok;
         end
         CMD_VICTIM: begin
            ctl.has_rsp = set_ok;
            if (!any_free) begin
               new_lfsr            = lfsr_step;
               rsp.victim_way      = mod_tab[lfsr_step];
               rsp.victim_was_free = 1'b0;
               ctl.write           = set_ok;
            end
         end
         default: begin
            ctl.write = 1'b0;
         end
      endcase
   end

endmodule

FILE: hw/rtl/lfsr_cache_victim_select.sv
// Top level: pseudo-random victim select with per-set valid bits and LFSRs.
//
//  channel  ports                          direction  transfer when
//  req      req_valid req_stall req_data   in         req_valid && !req_stall
//  rsp      rsp_valid rsp_stall rsp_data   out        rsp_valid && !rsp_stall
//
// One item per cycle while req_stall is low. A victim result passes the s1 registers, then rsp_data_ff.
// Set rows sit in a memory read at transfer; the last write is bypassed into the
// update stage, so back-to-back items on one set are exact.
// Reset clears every per-row flag together; no clearing sweep.
// req_stall rises only while a result waits on a stalled rsp channel.
module lfsr_cache_victim_select #(
   parameter int SETS = 64,
   parameter int WAYS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lcvs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lcvs_pkg::rsp_type rsp_data
);
   import lcvs_pkg::*;

   localparam int DEPTH = (SETS < 64) ? SETS : 64;
   localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int RW    = WAYS + 4;

   logic [RW-1:0]    mem [DEPTH];
   logic [DEPTH-1:0] row_init_ff;

   logic             s1_valid_ff;
   req_type          s1_item_ff;
   logic [RW-1:0]    rd_row_ff;
   logic             rd_init_ff;

   logic             byp_valid_ff;
   logic [5:0]       byp_set_ff;
   logic [RW-1:0]    byp_row_ff;

   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;

   logic             req_acc;
   logic             s1_adv;
   logic             s1_ok;
   logic             mem_we;
   logic [IW-1:0]    rd_idx;
   logic [IW-1:0]    wr_idx;
   logic [RW-1:0]    cur_row;
   logic [WAYS-1:0]  new_valid;
   logic [3:0]       new_lfsr;
   rsp_type          upd_rsp;
   upd_ctl_type      upd_ctl;

   assign s1_ok   = (32'(s1_item_ff.set_index) < SETS);
   assign s1_adv  = s1_valid_ff && !(upd_ctl.has_rsp && rsp_valid_ff && rsp_stall);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_acc = req_valid && !req_stall;
   assign mem_we  = s1_adv && upd_ctl.write;
   assign rd_idx  = req_data.set_index[IW-1:0];
   assign wr_idx  = s1_item_ff.set_index[IW-1:0];

   always_comb begin
      if (byp_valid_ff && (byp_set_ff == s1_item_ff.set_index)) begin
         cur_row = byp_row_ff;
      end else if (rd_init_ff) begin
         cur_row = rd_row_ff;
      end else begin
         cur_row = {LFSR_SEED, {WAYS{1'b0}}};
      end
   end

   lcvs_row_update #(
      .WAYS (WAYS)
   ) u_row_update (
      .item      (s1_item_ff),
      .set_ok    (s1_ok),
      .row_valid (cur_row[WAYS-1:0]),
      .row_lfsr  (cur_row[RW-1:WAYS]),
      .new_valid (new_valid),
      .new_lfsr  (new_lfsr),
      .rsp       (upd_rsp),
      .ctl       (upd_ctl)
   );

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_idx] <= {new_lfsr, new_valid};
      end
      if (req_acc) begin
         rd_row_ff <= mem[rd_idx];
         rd_init_ff <= row_init_ff[rd_idx];
         s1_item_ff <= req_data;
      end
      if (mem_we) begin
         byp_set_ff <= s1_item_ff.set_index;
         byp_row_ff <= {new_lfsr, new_valid};
      end
      if (s1_adv && upd_ctl.has_rsp) begin
         rsp_data_ff <= upd_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_init_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         byp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (mem_we) begin
            row_init_ff[wr_idx] <= 1'b1;
            byp_valid_ff        <= 1'b1;
         end
         if (req_acc) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv && upd_ctl.has_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && upd_ctl.has_rsp && rsp_valid_ff)
      else $error("request stalled without a blocked result");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !s1_valid_ff)
      else $error("pipeline not empty after reset");

   a_bypass_tracks_write: assert property (@(posedge clock) disable iff (reset)
      mem_we |=> byp_valid_ff && (byp_set_ff == $past(s1_item_ff.set_index)))
      else $error("bypass does not hold the last row write");

   a_lfsr_only_when_full: assert property (@(posedge clock) disable iff (reset)
      s1_adv && upd_ctl.has_rsp && !upd_rsp.victim_was_free |-> &cur_row[WAYS-1:0])
      else $error("LFSR victim chosen while a way was free");

endmodule
